FILE: hw/rtl/fdec_pkg.sv
// ----------------------------------------------------------------------------
// fdec_pkg
// Shared types and constants for the decimating FIR filter.
// ----------------------------------------------------------------------------
package fdec_pkg;

    localparam int NUM_CELLS   = 128;
    localparam int STEP_W      = $clog2(NUM_CELLS);
    localparam int SAMPLE_W    = 16;
    localparam int PROD_W      = 2 * SAMPLE_W;
    localparam int ACC_W       = PROD_W + STEP_W;   // room for NUM_CELLS full-scale products
    localparam int FRAC_BITS   = 15;                // Q1.15 coefficients
    localparam int MAG_W       = ACC_W - FRAC_BITS;
    localparam int TAPS_W      = 8;

    localparam logic [TAPS_W-1:0] TAP_COUNT_RESET = 8'd91;

    // func codes of an input word
    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [PROD_W-1:0]   prod_t;
    typedef logic signed [ACC_W-1:0]    acc_t;
    typedef logic [STEP_W-1:0]          step_t;
    typedef logic [TAPS_W-1:0]          taps_t;

    localparam sample_t SAMPLE_MAX = 16'sh7FFF;
    localparam sample_t SAMPLE_MIN = 16'sh8000;

    // ring control common to all cells
    typedef struct packed {
        logic shift;    // new sample enters cell 0, line moves one place
        logic rotate;   // ring turns one place toward cell 0
    } cell_ctrl_t;

    // multiply-accumulate control
    typedef struct packed {
        logic clear;    // zero the accumulator for a new sum
        logic mul_en;   // cell 0 holds a tap that is in use
    } mac_ctrl_t;

endpackage

FILE: hw/rtl/fdec_if.sv
// ----------------------------------------------------------------------------
// fdec_in_if / fdec_out_if
// Valid/ready channels carrying the filter's input and result words.
// ----------------------------------------------------------------------------
interface fdec_in_if;
    import fdec_pkg::*;

    logic                valid;
    logic                ready;
    logic                func;
    logic [STEP_W-1:0]   coeff_index;
    sample_t             coeff_value;
    sample_t             sample_in;

    modport source (output valid, func, coeff_index, coeff_value, sample_in, input ready);
    modport sink   (input valid, func, coeff_index, coeff_value, sample_in, output ready);
endinterface

interface fdec_out_if;
    import fdec_pkg::*;

    logic    valid;
    logic    ready;
    sample_t sample_out;
    logic    saturated;

    modport source (output valid, sample_out, saturated, input ready);
    modport sink   (input valid, sample_out, saturated, output ready);
endinterface

FILE: hw/rtl/fdec_cell.sv
// ----------------------------------------------------------------------------
// fdec_cell
// One tap of the ring: a delayed sample and its coefficient.
// ----------------------------------------------------------------------------
module fdec_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  fdec_pkg::cell_ctrl_t ctrl,
    input  logic                 load_sel,
    input  fdec_pkg::sample_t    load_value,
    input  fdec_pkg::sample_t    x_prev,    // from the cell one place newer
    input  fdec_pkg::sample_t    x_next,    // from the cell one place toward the tail
    input  fdec_pkg::sample_t    c_next,
    output fdec_pkg::sample_t    x,
    output fdec_pkg::sample_t    c
);
    import fdec_pkg::*;

    sample_t x_reg;
    sample_t c_reg;

    // delay line resets to silence
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg <= '0;
        end
        else if (ctrl.shift)
        begin
            x_reg <= x_prev;
        end
        else if (ctrl.rotate)
        begin
            x_reg <= x_next;
        end
    end

    // coefficient: no reset, undefined until loaded
    always_ff @(posedge clk)
    begin
        if (ctrl.rotate)
        begin
            c_reg <= c_next;
        end
        else if (load_sel)
        begin
            c_reg <= load_value;
        end
    end

    assign x = x_reg;
    assign c = c_reg;

endmodule

FILE: hw/rtl/fdec_mac.sv
// ----------------------------------------------------------------------------
// fdec_mac
// Multiply-accumulate at the ring head, then Q1.15 scaling and saturation.
// ----------------------------------------------------------------------------
module fdec_mac (
    input  logic                 clk,
    input  logic                 rst_n,
    input  fdec_pkg::mac_ctrl_t  ctrl,
    input  fdec_pkg::sample_t    x,
    input  fdec_pkg::sample_t    c,
    output fdec_pkg::sample_t    q,
    output logic                 sat,
    output logic                 busy
);
    import fdec_pkg::*;

    prod_t             prod_reg;
    logic              prod_vld_reg;
    acc_t              acc_reg;

    logic              neg;
    logic [ACC_W-1:0]  mag;
    logic [MAG_W-1:0]  shifted;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
        end
        else
        begin
            prod_vld_reg <= ctrl.mul_en & ~ctrl.clear;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= x * c;
        if (ctrl.clear)
        begin
            acc_reg <= '0;
        end
        else if (prod_vld_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    // truncate toward zero: scale the magnitude, then restore the sign
    always_comb
    begin
        neg     = acc_reg[ACC_W-1];
        mag     = neg ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
        shifted = mag[ACC_W-1:FRAC_BITS];
        sat     = 1'b0;
        if (neg)
        begin
            if (shifted > MAG_W'(32768))
            begin
                q   = SAMPLE_MIN;
                sat = 1'b1;
            end
            else
            begin
                q = sample_t'(-shifted[SAMPLE_W-1:0]);
            end
        end
        else
        begin
            if (shifted > MAG_W'(32767))
            begin
                q   = SAMPLE_MAX;
                sat = 1'b1;
            end
            else
            begin
                q = sample_t'(shifted[SAMPLE_W-1:0]);
            end
        end
    end

    assign busy = prod_vld_reg;

endmodule

FILE: hw/rtl/fir_decimate_by_two_top.sv
// ----------------------------------------------------------------------------
// fir_decimate_by_two_top
// Direct-form FIR filter with decimation by two, built as a ring of tap cells.
// ----------------------------------------------------------------------------
// Usage:
//   items   : input words. func = load puts coeff_value into tap coeff_index;
//             func = sample shifts sample_in into the delay line.
//   results : one word per even-numbered sample since reset: sample_out and
//             the saturated flag.
//   cfg_we / cfg_wdata : tap_count, written while idle (reset 91, >128 acts
//             as 128, 0 gives a zero result).
// Sequence:
//   A load or an odd-numbered sample is taken in idle and leaves the block
//   idle. An even-numbered sample turns the 128-cell ring once past the
//   multiplier at cell 0, one tap per cycle; a drain state then adds the
//   last product, and a finish state scales, saturates and, once the output
//   register is free, loads the result into it. The block then returns to
//   idle for the next word.
// Reset: the delay line clears to zero, the phase restarts on an even sample,
//   coefficients stay undefined until loaded.
// Stall: if the previous result has not been taken when a new one is ready,
//   the block holds the new result and accepts no word until it can be stored.
// ----------------------------------------------------------------------------
module fir_decimate_by_two_top (
    input  logic                 clk,
    input  logic                 rst_n,
    fdec_in_if.sink              items,
    fdec_out_if.source           results,
    input  logic                 cfg_we,
    input  fdec_pkg::taps_t      cfg_wdata
);
    import fdec_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ROT   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_FIN   = 2'd3;

    logic [1:0] state_reg, state_next;
    step_t      step_reg, step_next;
    logic       odd_phase_reg;
    taps_t      tap_count_reg;

    logic       out_valid_reg;
    sample_t    out_sample_reg;
    logic       out_sat_reg;

    logic       accept;
    logic       load_acc;
    logic       sample_acc;
    logic       out_load;

    cell_ctrl_t cell_ctrl;
    mac_ctrl_t  mac_ctrl;

    sample_t    x_w [NUM_CELLS];
    sample_t    c_w [NUM_CELLS];

    sample_t    mac_q;
    logic       mac_sat;
    logic       mac_busy;

    // --- input handshake ---
    assign items.ready = (state_reg == ST_IDLE);
    assign accept      = items.valid & items.ready;
    assign load_acc    = accept & (items.func == FUNC_LOAD);
    assign sample_acc  = accept & (items.func == FUNC_SAMPLE);

    // --- ring control ---
    always_comb
    begin
        cell_ctrl.shift  = sample_acc;
        cell_ctrl.rotate = (state_reg == ST_ROT);
        mac_ctrl.clear   = sample_acc;
        mac_ctrl.mul_en  = (state_reg == ST_ROT) && ({1'b0, step_reg} < tap_count_reg);
    end

    // --- tap cells: cell k holds x[n-k] and coeff k when the ring is home ---
    for (genvar k = 0; k < NUM_CELLS; k++)
    begin : g_cell
        fdec_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (cell_ctrl),
            .load_sel   (load_acc && (items.coeff_index == STEP_W'(k))),
            .load_value (items.coeff_value),
            .x_prev     ((k == 0) ? items.sample_in : x_w[(k + NUM_CELLS - 1) % NUM_CELLS]),
            .x_next     (x_w[(k + 1) % NUM_CELLS]),
            .c_next     (c_w[(k + 1) % NUM_CELLS]),
            .x          (x_w[k]),
            .c          (c_w[k])
        );
    end

    // --- multiply-accumulate at the ring head ---
    fdec_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (mac_ctrl),
        .x     (x_w[0]),
        .c     (c_w[0]),
        .q     (mac_q),
        .sat   (mac_sat),
        .busy  (mac_busy)
    );

    // --- sequencer ---
    assign out_load = (state_reg == ST_FIN) && (!out_valid_reg || results.ready);

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_IDLE:
            begin
                step_next = '0;
                if (sample_acc && !odd_phase_reg)
                begin
                    state_next = ST_ROT;
                end
            end
            ST_ROT:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == step_t'(NUM_CELLS - 1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            odd_phase_reg <= 1'b0;
            tap_count_reg <= TAP_COUNT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            if (sample_acc)
            begin
                odd_phase_reg <= ~odd_phase_reg;
            end
            if (cfg_we)
            begin
                tap_count_reg <= cfg_wdata;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // output payload: loaded only when the register is free or being emptied
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_sample_reg <= mac_q;
            out_sat_reg    <= mac_sat;
        end
    end

    assign results.valid      = out_valid_reg;
    assign results.sample_out = out_sample_reg;
    assign results.saturated  = out_sat_reg;

    // --- checks ---
    // an even-numbered sample starts a ring turn
    a_even_starts: assert property (@(posedge clk) disable iff (!rst_n)
        sample_acc && !odd_phase_reg |=> state_reg == ST_ROT)
        else $error("even sample did not start a filter pass");

    // an odd-numbered sample gives no result and leaves the block ready
    a_odd_idle: assert property (@(posedge clk) disable iff (!rst_n)
        sample_acc && odd_phase_reg |=> state_reg == ST_IDLE)
        else $error("odd sample started a filter pass");

    // a flagged result is clamped to full scale
    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.saturated |->
            results.sample_out == SAMPLE_MAX || results.sample_out == SAMPLE_MIN)
        else $error("saturated flag without a full-scale value");

    // the last product has been added before the result is formed
    a_drained: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FIN |-> !mac_busy)
        else $error("result formed with a product still pending");

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the decimate-by-two FIR filter: directed extremes,
// tap count limits, output back-pressure, then randomized coefficient and
// sample streams under several tap counts, all checked against a predictor.
// ----------------------------------------------------------------------------
module tb_top;
    import fdec_pkg::*;

    localparam int BUSY_CYCLES = 140;    // one even-sample sum plus margin
    localparam int HOLD_CYCLES = 400;    // long receiver hold-off
    localparam int STALL_LIMIT = 5000;   // watchdog: cycles with no handshake
    localparam int PHASE_WORDS = 40;     // random words per tap-count phase
    localparam int RELOAD_MAX  = 40;     // taps refreshed at a phase start
    localparam int REPORT_MAX  = 10;

    typedef enum int {COEF_SMALL, COEF_FULL, COEF_SPARSE, COEF_MIXED} coeff_profile_t;

    typedef struct packed {
        sample_t sample_out;
        logic    saturated;
    } fir_result_t;

    logic  clk = 1'b0;
    logic  rst_n;
    logic  cfg_we;
    taps_t cfg_wdata;

    fdec_in_if  items_if ();
    fdec_out_if results_if ();

    fir_decimate_by_two_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .items     (items_if),
        .results   (results_if),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ---- filter predictor state ---------------------------------------------
    sample_t     tap_history [NUM_CELLS];   // delay line, newest at next_slot-1
    sample_t     coeff_bank  [NUM_CELLS];
    int          next_slot;
    logic        odd_sample;                // set: next sample gives no result
    taps_t       taps_in_use;
    fir_result_t expected_outputs [$];

    int mismatches     = 0;
    int stalled_cycles = 0;
    bit no_idle        = 1'b0;   // both sides run flat out while set
    bit hold_request   = 1'b0;   // asks the receiver for a long hold-off

    // Track one accepted word; even samples queue the filtered result.
    task automatic filter_accept(logic func, step_t idx, sample_t cval, sample_t smp);
        longint      acc;
        longint      q;
        int          taps;
        int          j;
        fir_result_t res;
        if (func == FUNC_LOAD)
        begin
            coeff_bank[idx] = cval;
            return;
        end
        tap_history[next_slot] = smp;
        if (!odd_sample)
        begin
            acc  = 0;
            taps = (taps_in_use > NUM_CELLS) ? NUM_CELLS : int'(taps_in_use);
            for (j = 0; j < taps; j++)
                acc += longint'(coeff_bank[j]) *
                       longint'(tap_history[(next_slot + NUM_CELLS - j) % NUM_CELLS]);
            // scale toward zero, then clamp to the sample range
            q = (acc < 0) ? -((-acc) >>> FRAC_BITS) : (acc >>> FRAC_BITS);
            if (q > longint'(SAMPLE_MAX))
            begin
                res.sample_out = SAMPLE_MAX;
                res.saturated  = 1'b1;
            end
            else if (q < longint'(SAMPLE_MIN))
            begin
                res.sample_out = SAMPLE_MIN;
                res.saturated  = 1'b1;
            end
            else
            begin
                res.sample_out = sample_t'(q);
                res.saturated  = 1'b0;
            end
            expected_outputs.push_back(res);
        end
        next_slot  = (next_slot + 1) % NUM_CELLS;
        odd_sample = ~odd_sample;
    endtask

    function automatic sample_t pick_sample();
        case ($urandom_range(9))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2:       return sample_t'(int'($urandom_range(512)) - 256);
            default: return sample_t'($urandom);
        endcase
    endfunction

    function automatic sample_t pick_coeff(coeff_profile_t profile);
        int roll;
        roll = $urandom_range(9);
        case (profile)
            COEF_SMALL:  return sample_t'(int'($urandom_range(1023)) - 512);
            COEF_FULL:   return sample_t'($urandom);
            COEF_SPARSE: return (roll < 8) ? sample_t'(0) : sample_t'($urandom);
            default:
            begin
                if (roll == 0)
                    return SAMPLE_MAX;
                else if (roll == 1)
                    return SAMPLE_MIN;
                else
                    return sample_t'(int'($urandom_range(8191)) - 4096);
            end
        endcase
    endfunction

    // ---- input side ---------------------------------------------------------
    // Offer one word and return at the edge where it is taken. valid stays
    // high between back-to-back words; it only drops for an idle gap.
    task automatic send_word(logic func, step_t idx, sample_t cval, sample_t smp);
        if (!no_idle && $urandom_range(99) < 19)
        begin
            items_if.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < 19);
        end
        items_if.valid       <= 1'b1;
        items_if.func        <= func;
        items_if.coeff_index <= idx;
        items_if.coeff_value <= cval;
        items_if.sample_in   <= smp;
        do
            @(posedge clk);
        while (!items_if.ready);
        filter_accept(func, idx, cval, smp);
    endtask

    // Index and coefficient fields are don't-care on a sample word; fill them
    // with noise so the block is seen to ignore them. Same for sample_in on loads.
    task automatic send_sample(sample_t smp);
        send_word(FUNC_SAMPLE, step_t'($urandom), sample_t'($urandom), smp);
    endtask

    task automatic send_load(step_t idx, sample_t cval);
        send_word(FUNC_LOAD, idx, cval, sample_t'($urandom));
    endtask

    task automatic load_bank(int count, coeff_profile_t profile);
        int i;
        for (i = 0; i < count; i++)
            send_load(step_t'(i), pick_coeff(profile));
    endtask

    // Drain all results, then give a trailing load or odd sample time to
    // retire before touching the register.
    task automatic wait_for_idle();
        items_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_outputs.size() != 0);
        repeat (BUSY_CYCLES) @(posedge clk);
    endtask

    task automatic set_tap_count(taps_t taps);
        wait_for_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= taps;
        @(posedge clk);
        cfg_we      <= 1'b0;
        taps_in_use  = taps;
    endtask

    // ---- tests --------------------------------------------------------------
    // Every coefficient is written before the first sample, so no sum ever
    // reads an unloaded tap. First sums run at the reset tap count.
    task automatic test_reset_tap_count();
        int i;
        load_bank(NUM_CELLS, COEF_MIXED);
        for (i = 0; i < 12; i++)
            send_sample(pick_sample());
    endtask

    // One tap: output is just coeff * sample. Each probe goes in twice so it
    // lands on an even slot whatever the phase.
    task automatic test_single_tap();
        sample_t probes [4];
        int      i;
        probes = '{SAMPLE_MAX, SAMPLE_MIN, -16'sd1, 16'sd1};
        set_tap_count(taps_t'(1));
        send_load(step_t'(0), SAMPLE_MAX);
        for (i = 0; i < 8; i++)
            send_sample(probes[i / 2]);
        // most negative coefficient times most negative sample overflows
        send_load(step_t'(0), SAMPLE_MIN);
        for (i = 0; i < 4; i++)
            send_sample((i < 2) ? SAMPLE_MIN : SAMPLE_MAX);
    endtask

    // Zero taps, register values past the ring length, and full-scale sums
    // clamping both ways.
    task automatic test_tap_count_limits();
        int i;
        set_tap_count(taps_t'(0));
        for (i = 0; i < 4; i++)
            send_sample(pick_sample());
        set_tap_count(taps_t'(255));
        for (i = 0; i < NUM_CELLS; i++)
            send_load(step_t'(i), SAMPLE_MAX);
        for (i = 0; i < 8; i++)
            send_sample((i < 4) ? SAMPLE_MAX : SAMPLE_MIN);
        // a load in the middle of a sample stream
        send_load(step_t'(NUM_CELLS - 1), SAMPLE_MIN);
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MAX);
        set_tap_count(taps_t'(NUM_CELLS + 1));
        for (i = 0; i < 4; i++)
            send_sample(pick_sample());
    endtask

    // Receiver holds off while words keep coming: the result register fills
    // and the block has to stall its input.
    task automatic test_output_backpressure();
        int i;
        set_tap_count(taps_t'(NUM_CELLS));
        load_bank(NUM_CELLS, COEF_SMALL);
        hold_request = 1'b1;
        for (i = 0; i < 12; i++)
            send_sample(pick_sample());
    endtask

    // Sender stops until every outstanding result is out, then resumes.
    task automatic test_sender_pause();
        int i;
        for (i = 0; i < 7; i++)
            send_sample(pick_sample());
        items_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_outputs.size() != 0);
        for (i = 0; i < 7; i++)
            send_sample(pick_sample());
    endtask

    // Phases of random traffic, each at its own tap count and coefficient
    // character. Loads are sprinkled through the sample stream.
    task automatic test_random_phases();
        taps_t          plan [12];
        coeff_profile_t profile;
        int             p;
        int             w;
        plan = '{8'd128, 8'd1, 8'd2, 8'd7, 8'd64, 8'd127, 8'd0, 8'd255, 8'd129,
                 8'd0, 8'd0, 8'd0};
        for (p = 9; p < 12; p++)
            plan[p] = taps_t'($urandom_range(NUM_CELLS, 1));
        for (p = 0; p < 12; p++)
        begin
            set_tap_count(plan[p]);
            profile = coeff_profile_t'(p % 4);
            no_idle = (p == 4);   // one phase with no gaps on either side
            load_bank((plan[p] > RELOAD_MAX) ? RELOAD_MAX : int'(plan[p]), profile);
            for (w = 0; w < PHASE_WORDS; w++)
            begin
                if ($urandom_range(99) < 8)
                    send_load(step_t'($urandom_range(NUM_CELLS - 1)), pick_coeff(profile));
                else
                    send_sample(pick_sample());
            end
            no_idle = 1'b0;
        end
    endtask

    // ---- main sequence ------------------------------------------------------
    initial
    begin
        int i;
        rst_n                <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_wdata            <= '0;
        items_if.valid       <= 1'b0;
        items_if.func        <= FUNC_LOAD;
        items_if.coeff_index <= '0;
        items_if.coeff_value <= '0;
        items_if.sample_in   <= '0;
        for (i = 0; i < NUM_CELLS; i++)
        begin
            tap_history[i] = '0;
            coeff_bank[i]  = '0;
        end
        next_slot   = 0;
        odd_sample  = 1'b0;
        taps_in_use = TAP_COUNT_RESET;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_tap_count();
        test_single_tap();
        test_tap_count_limits();
        test_output_backpressure();
        test_sender_pause();
        test_random_phases();

        wait_for_idle();
        if (mismatches == 0 && expected_outputs.size() == 0)
            $display("fir_decimate_by_two_top test passed");
        else
            $display("fir_decimate_by_two_top test failed");
        $finish;
    end

    // ---- output side --------------------------------------------------------
    // Random ready, or a counted hold-off when a test asks for one.
    initial
    begin
        results_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request      = 1'b0;
                results_if.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
            end
            else
                results_if.ready <= no_idle || ($urandom_range(99) >= 19);
        end
    end

    // Each taken result word against the oldest prediction.
    always @(posedge clk)
    begin
        fir_result_t want;
        if (rst_n && results_if.valid && results_if.ready)
        begin
            if (expected_outputs.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("%0t: unexpected result: sample_out %0d saturated %0b",
                             $realtime, results_if.sample_out, results_if.saturated);
            end
            else
            begin
                want = expected_outputs.pop_front();
                if (results_if.sample_out !== want.sample_out ||
                    results_if.saturated !== want.saturated)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("%0t: mismatch: out exp %0d got %0d, sat exp %0b got %0b",
                                 $realtime, want.sample_out, results_if.sample_out,
                                 want.saturated, results_if.saturated);
                end
            end
        end
    end

    // Watchdog: too long without any handshake or register write means a hang.
    always @(posedge clk)
    begin
        if (!rst_n || cfg_we || (items_if.valid && items_if.ready) ||
            (results_if.valid && results_if.ready))
            stalled_cycles = 0;
        else
            stalled_cycles++;
        if (stalled_cycles >= STALL_LIMIT)
        begin
            $display("fir_decimate_by_two_top test failed");
            $finish;
        end
    end

endmodule

FILE: fir_decimate_by_two_top.f
hw/rtl/fdec_pkg.sv
hw/rtl/fdec_if.sv
hw/rtl/fdec_cell.sv
hw/rtl/fdec_mac.sv
hw/rtl/fir_decimate_by_two_top.sv
bench/tb_top.sv
